// File: rtl/core/bdq_pkg.sv
// Package for the block DCT quantizer: sizes, cosine, quantization and zig-zag tables.
// Used by the channel interfaces and the top level; depends on nothing else.
`default_nettype none
package bdq_pkg;

    localparam int BLOCK_DIM  = 8;
    localparam int BLOCK_AREA = BLOCK_DIM * BLOCK_DIM;
    localparam int IDX_W      = $clog2(BLOCK_AREA);
    localparam int SAMPLE_W   = 8;
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 6;
    localparam int COS_W      = 16;
    localparam int ROW_W      = 26;
    localparam int PROD_W     = COS_W + ROW_W;
    localparam int ACC_W      = 44;
    localparam int QUANT_W    = 7;
    localparam int DIVD_W     = 13;
    localparam int PIXEL_BIAS = 128;

    typedef logic signed [COS_W-1:0] t_cos;

    localparam logic [COS_W-1:0] COS_HALF [9] = '{
        16'd16384, 16'd16069, 16'd15137, 16'd13623, 16'd11585,
        16'd9102, 16'd6270, 16'd3196, 16'd0
    };
    localparam logic [COS_W-1:0] DC_GAIN = 16'd11585;

    localparam logic [QUANT_W-1:0] QUANT_LUMA [BLOCK_AREA] = '{
        7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
        7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
        7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
        7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
        7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
        7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
        7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
        7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
    };

    localparam logic [QUANT_W-1:0] QUANT_CHROMA [BLOCK_AREA] = '{
        7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
    };

    localparam logic [IDX_W-1:0] ZIGZAG [BLOCK_AREA] = '{
        6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    // Signed Q1.15 value of c(u) * cos((2x+1) u pi / 16).
    function automatic t_cos cos_q15(input logic [2:0] u, input logic [2:0] x);
        logic [6:0] ang;
        logic [4:0] a;
        logic [4:0] f;
        t_cos       r;
        ang = {3'b000, x, 1'b1} * {4'b0000, u};
        a   = ang[4:0];
        f   = (a > 5'd16) ? 5'(6'd32 - {1'b0, a}) : a;
        if (u == 3'd0) begin
            r = t_cos'(DC_GAIN);
        end else if (f > 5'd8) begin
            r = -t_cos'(COS_HALF[4'(5'd16 - f)]);
        end else begin
            r = t_cos'(COS_HALF[4'(f)]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bdq_if.sv
// Valid/ready channel interfaces for the sample input and the coefficient output.
// Depends on bdq_pkg for field widths.
`default_nettype none
interface bdq_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::SAMPLE_W-1:0]  sample;
    logic                          use_chroma_table;
    modport source (output valid, sample, use_chroma_table, input ready);
    modport sink (input valid, sample, use_chroma_table, output ready);
endinterface

interface bdq_out_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::SAMPLE_W-1:0]  coefficient;
    logic [bdq_pkg::POS_W-1:0]     zigzag_position;
    logic                          last;
    modport source (output valid, coefficient, zigzag_position, last, input ready);
    modport sink (input valid, coefficient, zigzag_position, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bdq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
`default_nettype none
module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/block_dct_quantizer.sv
// Top level of the block DCT quantizer: sample store, shared MAC, divider and output.
// Depends on bdq_pkg, bdq_if (bdq_in_if, bdq_out_if) and bdq_ram.
//
// Usage:
//   Samples of one 8x8 block arrive on i_in in raster order, one per transfer.
//   use_chroma_table is taken from the first sample of each block only.
//   After the 64th sample the block stops taking samples and computes the
//   orthonormal 2-D DCT, quantizes, and sends the first coefficient_count
//   coefficients in zig-zag order on o_out, the final one marked by last.
//   i_in.ready stays high throughout filling, so samples are taken back to back.
//   Processing: the row pass runs 64 row sums of 8 taps each through one
//   multiplier fed from the sample RAM. The column pass then computes each
//   emitted coefficient with 8 taps read from the row RAM and a 13-step
//   restoring divider by the quantization entry, and offers it on o_out.
//   The next coefficient starts only after the previous one is taken.
//   When the receiver stalls the coefficient is held in the output register
//   and the sequencer waits; nothing is lost or repeated.
//   Reset (synchronous, active low) empties the block, selects luma and sets
//   coefficient_count to 64. i_cfg_we writes coefficient_count; 0 acts as 1
//   and values above 64 act as 64. Write it only while the block is idle.
`default_nettype none
module block_dct_quantizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bdq_in_if.sink                             i_in,
    bdq_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [bdq_pkg::COUNT_W-1:0]   i_cfg_data
);
    localparam int IW = bdq_pkg::IDX_W;

    // Sequencer states.
    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                   r_state;
    logic [IW-1:0]                r_cnt;        // sample position within the block
    logic                         r_tsel;       // chroma table selected for the block
    logic [bdq_pkg::COUNT_W-1:0]  r_coef_count;
    logic [IW-1:0]                r_nlast;      // index of the last emitted coefficient
    logic [IW-1:0]                r_outer;      // row pass: y*8+u; column pass: zig-zag k
    logic [3:0]                   r_tap;        // taps issued; bit 3 set when all are out
    logic                         r_p1_v, r_p1_first, r_p1_last;
    logic                         r_p2_v, r_p2_first, r_p2_last;
    logic                         r_done;
    logic [3:0]                   r_dstep;

    // Datapath registers.
    bdq_pkg::t_cos                      r_p1_coef;
    logic signed [bdq_pkg::PROD_W-1:0]  r_p2_prod;
    logic signed [bdq_pkg::ACC_W-1:0]   r_acc;
    logic [bdq_pkg::DIVD_W-1:0]         r_quo;
    logic [bdq_pkg::QUANT_W-1:0]        r_rem;
    logic [bdq_pkg::QUANT_W-1:0]        r_q;
    logic [bdq_pkg::SAMPLE_W-1:0]       r_out_coef;
    logic [bdq_pkg::POS_W-1:0]          r_out_pos;
    logic                               r_out_last;

    logic                               in_xfer, out_xfer, issue;
    logic [IW-1:0]                      zz_idx;
    logic [2:0]                         tap;
    logic [IW-1:0]                      samp_raddr, row_raddr;
    logic [bdq_pkg::SAMPLE_W-1:0]       samp_rdata;
    logic [bdq_pkg::ROW_W-1:0]          row_rdata;
    bdq_pkg::t_cos                      coef;
    logic signed [bdq_pkg::ROW_W-1:0]   operand;
    logic [bdq_pkg::ACC_W-1:0]          mag, biased;
    logic [bdq_pkg::QUANT_W-1:0]        qsel;
    logic [bdq_pkg::QUANT_W:0]          rem_sh;
    logic                               rem_ge;
    logic [bdq_pkg::SAMPLE_W-1:0]       sat_val;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_FILL);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.coefficient = r_out_coef;
    assign o_out.zigzag_position = r_out_pos;
    assign o_out.last = r_out_last;

    assign tap    = r_tap[2:0];
    assign issue  = ((r_state == S_ROW) || (r_state == S_COL)) && !r_tap[3];
    assign zz_idx = bdq_pkg::ZIGZAG[r_outer];

    // Row pass walks x along row y; column pass walks y down column u.
    assign samp_raddr = {r_outer[5:3], tap};
    assign row_raddr  = {tap, zz_idx[2:0]};
    assign coef = (r_state == S_ROW) ? bdq_pkg::cos_q15(r_outer[2:0], tap)
                                     : bdq_pkg::cos_q15(zz_idx[5:3], tap);

    bdq_ram #(.WIDTH(bdq_pkg::SAMPLE_W), .DEPTH(bdq_pkg::BLOCK_AREA)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_cnt),
        .i_wdata (i_in.sample),
        .i_re    (issue && (r_state == S_ROW)),
        .i_raddr (samp_raddr),
        .o_rdata (samp_rdata)
    );

    bdq_ram #(.WIDTH(bdq_pkg::ROW_W), .DEPTH(bdq_pkg::BLOCK_AREA)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_done && (r_state == S_ROW)),
        .i_waddr (r_outer),
        .i_wdata (r_acc[bdq_pkg::ROW_W-1:0]),
        .i_re    (issue && (r_state == S_COL)),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // The pass cannot change while taps are in flight, so the state picks the operand.
    always_comb begin
        if (r_state == S_ROW) begin
            operand = bdq_pkg::ROW_W'($signed({1'b0, samp_rdata}) -
                                      $signed(10'(bdq_pkg::PIXEL_BIAS)));
        end else begin
            operand = $signed(row_rdata);
        end
    end

    // Rounded magnitude: floor((|D| + q*2^29) / 2^30) is then divided by q.
    assign qsel   = r_tsel ? bdq_pkg::QUANT_CHROMA[zz_idx] : bdq_pkg::QUANT_LUMA[zz_idx];
    assign mag    = r_acc[bdq_pkg::ACC_W-1] ? bdq_pkg::ACC_W'(-r_acc)
                                            : bdq_pkg::ACC_W'(r_acc);
    assign biased = mag + {8'd0, qsel, 29'd0};

    assign rem_sh = {r_rem, r_quo[bdq_pkg::DIVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_q});

    // Quotient is final once the last divider step has been registered.
    always_comb begin
        if (r_acc[bdq_pkg::ACC_W-1]) begin
            sat_val = (r_quo > 13'd128) ? 8'd0 : 8'(9'd128 - 9'(r_quo));
        end else begin
            sat_val = (r_quo > 13'd127) ? 8'd255 : 8'(9'd128 + 9'(r_quo));
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_cnt        <= '0;
            r_tsel       <= 1'b0;
            r_coef_count <= 7'(bdq_pkg::BLOCK_AREA);
            r_nlast      <= '1;
            r_outer      <= '0;
            r_tap        <= 4'd8;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_done       <= 1'b0;
            r_dstep      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_coef_count <= i_cfg_data;
            end
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_done <= r_p2_v && r_p2_last;
            if (issue) begin
                r_tap <= r_tap + 4'd1;
            end
            unique case (r_state)
                S_FILL: begin
                    if (in_xfer) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == '0) begin
                            r_tsel <= i_in.use_chroma_table;
                        end
                        if (r_cnt == '1) begin
                            r_state <= S_ROW;
                            r_outer <= '0;
                            r_tap   <= 4'd0;
                            if (r_coef_count == 7'd0) begin
                                r_nlast <= '0;
                            end else if (r_coef_count >= 7'(bdq_pkg::BLOCK_AREA)) begin
                                r_nlast <= '1;
                            end else begin
                                r_nlast <= IW'(r_coef_count - 7'd1);
                            end
                        end
                    end
                end
                S_ROW: begin
                    if (r_done) begin
                        r_outer <= r_outer + 1'b1;
                        r_tap   <= 4'd0;
                        if (r_outer == '1) begin
                            r_state <= S_COL;
                        end
                    end
                end
                S_COL: begin
                    if (r_done) begin
                        r_state <= S_DIV;
                        r_dstep <= '0;
                    end
                end
                S_DIV: begin
                    r_dstep <= r_dstep + 4'd1;
                    if (r_dstep == 4'(bdq_pkg::DIVD_W)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        if (r_outer == r_nlast) begin
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_COL;
                            r_outer <= r_outer + 1'b1;
                            r_tap   <= 4'd0;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // Datapath: MAC pipeline, divider and output register.
    always_ff @(posedge i_clk) begin
        r_p1_coef  <= coef;
        r_p1_first <= (tap == 3'd0);
        r_p1_last  <= (tap == 3'd7);
        r_p2_prod  <= r_p1_coef * operand;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        if (r_p2_v) begin
            r_acc <= (r_p2_first ? '0 : r_acc) + bdq_pkg::ACC_W'(r_p2_prod);
        end
        if (r_state == S_COL && r_done) begin
            r_quo <= biased[30 +: bdq_pkg::DIVD_W];
            r_rem <= '0;
            r_q   <= qsel;
        end else if (r_state == S_DIV && r_dstep != 4'(bdq_pkg::DIVD_W)) begin
            r_quo <= {r_quo[bdq_pkg::DIVD_W-2:0], rem_ge};
            r_rem <= rem_ge ? bdq_pkg::QUANT_W'(rem_sh - {1'b0, r_q})
                            : bdq_pkg::QUANT_W'(rem_sh);
        end
        if (r_state == S_DIV && r_dstep == 4'(bdq_pkg::DIVD_W)) begin
            r_out_coef <= sat_val;
            r_out_pos  <= r_outer;
            r_out_last <= (r_outer == r_nlast);
        end
    end

    // Checks.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input ready while a coefficient is offered");

    a_done_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_ROW || r_state == S_COL))
        else $error("MAC result outside a transform pass");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.last) |=> (r_state == S_FILL))
        else $error("block did not return to filling after the last transfer");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.zigzag_position <= r_nlast))
        else $error("zig-zag position beyond the coefficient count");

    a_cfg_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && in_xfer && r_cnt == '1 && r_coef_count == 7'd0) |=>
        (r_nlast == '0))
        else $error("zero coefficient count not treated as one");
endmodule
`default_nettype wire
